// ----- design/gbh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbh_pkg: shared types and constants for the GPIB byte handshake
// Phase codes, action codes, register indexes and the per-tick result record.
// ----------------------------------------------------------------------------
package gbh_pkg;

    localparam int unsigned TIMER_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_W   = 32;

    localparam logic [BYTE_W-1:0]  BYTE_RELEASED = 8'hFF;
    localparam logic [TIMER_W-1:0] TIMER_MAX     = 32'hFFFF_FFFF;
    localparam logic [TIMER_W-1:0] TIMEOUT_RST   = 32'd2000000;
    localparam logic [BYTE_W-1:0]  SETTLE_RST    = 8'd2;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_SETTLE  = 1'b1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_W_NRFD   = 3'd1,
        PH_W_SETTLE = 3'd2,
        PH_W_NDAC   = 3'd3,
        PH_R_DAVLO  = 3'd4,
        PH_R_DAVHI  = 3'd5
    } t_phase;

    typedef struct packed {
        logic              dav_drive;
        logic              eoi_drive;
        logic              nrfd_drive;
        logic              ndac_drive;
        logic [BYTE_W-1:0] dio_drive;
        logic              busy_res;
        logic              done_res;
        logic              status;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_end;
    } t_result;

endpackage

// ----- design/gbh_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbh_fsm: source/acceptor handshake state machine
// Holds the phase, wait timer and latched bytes; computes one result per
// transfer from the current state and the sampled bus lines.
// ----------------------------------------------------------------------------
module gbh_fsm (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [gbh_pkg::TIMER_W-1:0] i_timeout_ticks,
    input  logic [gbh_pkg::BYTE_W-1:0]  i_settle_ticks,
    input  logic [1:0]                 i_action,
    input  logic [gbh_pkg::BYTE_W-1:0]  i_tx_byte,
    input  logic                       i_tx_end,
    input  logic                       i_nrfd_line,
    input  logic                       i_ndac_line,
    input  logic                       i_dav_line,
    input  logic                       i_eoi_line,
    input  logic [gbh_pkg::BYTE_W-1:0]  i_dio_lines,
    output gbh_pkg::t_result           o_result
);
    import gbh_pkg::*;

    t_phase              r_phase,   n_phase;
    logic [TIMER_W-1:0]  r_timer,   n_timer;
    logic [BYTE_W-1:0]   r_tx_byte, n_tx_byte;
    logic                r_tx_end,  n_tx_end;
    logic [BYTE_W-1:0]   r_rx_byte, n_rx_byte;
    logic                r_rx_end,  n_rx_end;
    logic                r_listen,  n_listen;

    logic                timer_over;
    logic [TIMER_W-1:0]  timer_inc;
    logic [TIMER_W-1:0]  settle_cnt;
    logic                done;
    logic                fail;

    // hold state between transfers, advance on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_tx_byte <= '0;
            r_tx_end  <= 1'b0;
            r_rx_byte <= '0;
            r_rx_end  <= 1'b0;
            r_listen  <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_tx_byte <= n_tx_byte;
            r_tx_end  <= n_tx_end;
            r_rx_byte <= n_rx_byte;
            r_rx_end  <= n_rx_end;
            r_listen  <= n_listen;
        end
    end

    // unmet wait: fail past the timeout, else count up and saturate
    assign timer_over = (r_timer > i_timeout_ticks);
    assign timer_inc  = (r_timer == TIMER_MAX) ? r_timer : r_timer + TIMER_W'(1);
    assign settle_cnt = r_timer + TIMER_W'(1);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_tx_byte = r_tx_byte;
        n_tx_end  = r_tx_end;
        n_rx_byte = r_rx_byte;
        n_rx_end  = r_rx_end;
        n_listen  = r_listen;
        done      = 1'b0;
        fail      = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_action == ACT_WRITE) begin
                    n_tx_byte = i_tx_byte;
                    n_tx_end  = i_tx_end;
                    n_listen  = 1'b0;
                    n_phase   = PH_W_NRFD;
                    n_timer   = '0;
                end else if (i_action == ACT_READ) begin
                    n_listen  = 1'b1;
                    n_phase   = PH_R_DAVLO;
                    n_timer   = '0;
                end
            end
            PH_W_NRFD: begin
                if (i_nrfd_line) begin
                    n_phase = PH_W_SETTLE;
                    n_timer = '0;
                end else if (timer_over) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    fail    = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_W_SETTLE: begin
                // settle of zero behaves as one tick
                if (settle_cnt >= TIMER_W'(i_settle_ticks)) begin
                    n_phase = PH_W_NDAC;
                    n_timer = '0;
                end else begin
                    n_timer = settle_cnt;
                end
            end
            PH_W_NDAC: begin
                if (i_ndac_line) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else if (timer_over) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    fail    = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_R_DAVLO: begin
                if (!i_dav_line) begin
                    n_rx_byte = ~i_dio_lines;
                    n_rx_end  = ~i_eoi_line;
                    n_phase   = PH_R_DAVHI;
                    n_timer   = '0;
                end else if (timer_over) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    fail    = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
            PH_R_DAVHI: begin
                if (i_dav_line) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else if (timer_over) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                    fail    = 1'b1;
                end else begin
                    n_timer = timer_inc;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // drive bus levels from the state left after this tick
    always_comb begin
        o_result            = '0;
        o_result.dav_drive  = 1'b1;
        o_result.eoi_drive  = 1'b1;
        o_result.nrfd_drive = 1'b1;
        o_result.ndac_drive = 1'b1;
        o_result.dio_drive  = BYTE_RELEASED;
        if (n_listen) begin
            o_result.nrfd_drive = (n_phase == PH_R_DAVLO);
            o_result.ndac_drive = (n_phase == PH_R_DAVHI);
        end else if (n_phase == PH_W_SETTLE || n_phase == PH_W_NDAC) begin
            o_result.dio_drive = ~n_tx_byte;
            o_result.eoi_drive = ~n_tx_end;
            o_result.dav_drive = (n_phase != PH_W_NDAC);
        end
        o_result.busy_res = (n_phase != PH_IDLE);
        o_result.done_res = done;
        o_result.status   = fail;
        o_result.rx_byte  = n_rx_byte;
        o_result.rx_end   = n_rx_end;
    end

endmodule

// ----- design/gpib_byte_handshake.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpib_byte_handshake: IEEE-488 three-wire byte handshake engine
// Acts as source or acceptor for one byte; one input transfer is one tick.
// ----------------------------------------------------------------------------
// Each accepted input transfer is one sampling tick of the bus. The block
// takes one tick every clock cycle unless the output stalls: the state
// machine registers its phase and wait timer on each accepted tick, and the
// result for a tick appears in the output register on the cycle after the
// tick is accepted. Input ready stays high while the output register is
// empty or being drained in the same cycle, so with the consumer always
// ready the rate is one tick per cycle. Configuration writes take effect on the next tick.
// ----------------------------------------------------------------------------
module gpib_byte_handshake (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [gbh_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [gbh_pkg::BYTE_W-1:0]  i_tx_byte,
    input  logic                        i_tx_end,
    input  logic                        i_nrfd_line,
    input  logic                        i_ndac_line,
    input  logic                        i_dav_line,
    input  logic                        i_eoi_line,
    input  logic [gbh_pkg::BYTE_W-1:0]  i_dio_lines,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_dav_drive,
    output logic                        o_eoi_drive,
    output logic                        o_nrfd_drive,
    output logic                        o_ndac_drive,
    output logic [gbh_pkg::BYTE_W-1:0]  o_dio_drive,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_status,
    output logic [gbh_pkg::BYTE_W-1:0]  o_rx_byte,
    output logic                        o_rx_end
);
    import gbh_pkg::*;

    logic [TIMER_W-1:0] r_timeout_ticks;
    logic [BYTE_W-1:0]  r_settle_ticks;
    logic               r_out_valid;
    t_result            r_result;
    t_result            fsm_result;
    logic               accept;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RST;
            r_settle_ticks  <= SETTLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_timeout_ticks <= i_cfg_data;
                CFG_SETTLE:  r_settle_ticks  <= i_cfg_data[BYTE_W-1:0];
                default:     r_timeout_ticks <= r_timeout_ticks;
            endcase
        end
    end

    // take a tick when the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    gbh_fsm u_fsm (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (accept),
        .i_timeout_ticks (r_timeout_ticks),
        .i_settle_ticks  (r_settle_ticks),
        .i_action        (i_action),
        .i_tx_byte       (i_tx_byte),
        .i_tx_end        (i_tx_end),
        .i_nrfd_line     (i_nrfd_line),
        .i_ndac_line     (i_ndac_line),
        .i_dav_line      (i_dav_line),
        .i_eoi_line      (i_eoi_line),
        .i_dio_lines     (i_dio_lines),
        .o_result        (fsm_result)
    );

    // output register: load on accept, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= fsm_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_dav_drive  = r_result.dav_drive;
    assign o_eoi_drive  = r_result.eoi_drive;
    assign o_nrfd_drive = r_result.nrfd_drive;
    assign o_ndac_drive = r_result.ndac_drive;
    assign o_dio_drive  = r_result.dio_drive;
    assign o_busy_res   = r_result.busy_res;
    assign o_done_res   = r_result.done_res;
    assign o_status     = r_result.status;
    assign o_rx_byte    = r_result.rx_byte;
    assign o_rx_end     = r_result.rx_end;

    // a timeout is only reported with done, and a finished handshake is not busy
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_done_res && !o_busy_res)
        else $error("timeout status without done or while busy");

    // an accepted tick always shows up as a result on the next cycle
    a_accept_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted tick produced no result");

    // a stalled result blocks new ticks
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("tick accepted over a stalled result");

    // DAV is asserted only by a busy talker, never with listener lines driven
    a_dav_talker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_dav_drive |-> o_busy_res && o_nrfd_drive && o_ndac_drive)
        else $error("DAV asserted outside an active write");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the GPIB three-wire byte handshake
// Sends bus sampling ticks through the input channel and plays a
// reacting source or acceptor on the sampled lines. An in-bench copy of the
// handshake state machine works out the drive levels and status for every
// tick. Each output transfer is checked field by field, in order. Both
// channels idle and stall at random. The registers are rewritten between
// phases, including timeout zero and maximum and settle zero and maximum.
// ----------------------------------------------------------------------------
module tb;
    import gbh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    // action code with no meaning to the block; acts as a plain tick
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_end;
        logic              nrfd;
        logic              ndac;
        logic              dav;
        logic              eoi;
        logic [BYTE_W-1:0] dio;
    } bus_tick_t;

    // Tracks the handshake engine and queues the drive levels due per tick
    class handshake_predictor;
        logic [TIMER_W-1:0] timeout_lim;
        logic [BYTE_W-1:0]  settle_len;
        t_phase             phase;
        logic [TIMER_W-1:0] wait_count;
        logic [BYTE_W-1:0]  tx_hold;
        logic               tx_eoi;
        logic [BYTE_W-1:0]  rx_hold;
        logic               rx_eoi;
        logic               listening;
        t_result            due_levels[$];
        int unsigned        errors;

        function new();
            timeout_lim = TIMEOUT_RST;
            settle_len  = SETTLE_RST;
            phase       = PH_IDLE;
            wait_count  = '0;
            tx_hold     = '0;
            tx_eoi      = 1'b0;
            rx_hold     = '0;
            rx_eoi      = 1'b0;
            listening   = 1'b0;
            errors      = 0;
        endfunction

        function void configure(logic [TIMER_W-1:0] timeout, logic [BYTE_W-1:0] settle);
            timeout_lim = timeout;
            settle_len  = settle;
        endfunction

        // Count one unmet wait tick; report a failure once past the timeout
        function bit wait_lapsed();
            if (wait_count > timeout_lim)
                return 1'b1;
            if (wait_count != TIMER_MAX)
                wait_count++;
            return 1'b0;
        endfunction

        function void note_tick(bus_tick_t t);
            t_result r;
            logic    done;
            logic    fail;
            done = 1'b0;
            fail = 1'b0;

            // advance the handshake by one tick
            case (phase)
                PH_IDLE: begin
                    if (t.action == ACT_WRITE) begin
                        tx_hold    = t.tx_byte;
                        tx_eoi     = t.tx_end;
                        listening  = 1'b0;
                        phase      = PH_W_NRFD;
                        wait_count = '0;
                    end else if (t.action == ACT_READ) begin
                        listening  = 1'b1;
                        phase      = PH_R_DAVLO;
                        wait_count = '0;
                    end
                end
                PH_W_NRFD: begin
                    if (t.nrfd) begin
                        phase      = PH_W_SETTLE;
                        wait_count = '0;
                    end else if (wait_lapsed()) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                        fail  = 1'b1;
                    end
                end
                PH_W_SETTLE: begin
                    wait_count = wait_count + 1;
                    if (wait_count >= {24'd0, settle_len}) begin
                        phase      = PH_W_NDAC;
                        wait_count = '0;
                    end
                end
                PH_W_NDAC: begin
                    if (t.ndac) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                    end else if (wait_lapsed()) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                        fail  = 1'b1;
                    end
                end
                PH_R_DAVLO: begin
                    if (!t.dav) begin
                        rx_hold    = ~t.dio;
                        rx_eoi     = !t.eoi;
                        phase      = PH_R_DAVHI;
                        wait_count = '0;
                    end else if (wait_lapsed()) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                        fail  = 1'b1;
                    end
                end
                PH_R_DAVHI: begin
                    if (t.dav) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                    end else if (wait_lapsed()) begin
                        phase = PH_IDLE;
                        done  = 1'b1;
                        fail  = 1'b1;
                    end
                end
                default: phase = PH_IDLE;
            endcase

            // work out the line levels after the tick
            r.dav_drive  = 1'b1;
            r.eoi_drive  = 1'b1;
            r.nrfd_drive = 1'b1;
            r.ndac_drive = 1'b1;
            r.dio_drive  = BYTE_RELEASED;
            if (listening) begin
                r.nrfd_drive = (phase == PH_R_DAVLO);
                r.ndac_drive = (phase == PH_R_DAVHI);
            end else if (phase == PH_W_SETTLE || phase == PH_W_NDAC) begin
                r.dio_drive = ~tx_hold;
                if (tx_eoi)
                    r.eoi_drive = 1'b0;
                if (phase == PH_W_NDAC)
                    r.dav_drive = 1'b0;
            end
            r.busy_res = (phase != PH_IDLE);
            r.done_res = done;
            r.status   = fail;
            r.rx_byte  = rx_hold;
            r.rx_end   = rx_eoi;
            due_levels.push_back(r);
        endfunction

        function void compare(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_levels(t_result got);
            t_result want;
            if (due_levels.size() == 0) begin
                $error("output transfer with no tick outstanding");
                errors++;
                return;
            end
            want = due_levels.pop_front();
            compare("dav_drive", BYTE_W'(want.dav_drive), BYTE_W'(got.dav_drive));
            compare("eoi_drive", BYTE_W'(want.eoi_drive), BYTE_W'(got.eoi_drive));
            compare("nrfd_drive", BYTE_W'(want.nrfd_drive), BYTE_W'(got.nrfd_drive));
            compare("ndac_drive", BYTE_W'(want.ndac_drive), BYTE_W'(got.ndac_drive));
            compare("dio_drive", want.dio_drive, got.dio_drive);
            compare("busy_res", BYTE_W'(want.busy_res), BYTE_W'(got.busy_res));
            compare("done_res", BYTE_W'(want.done_res), BYTE_W'(got.done_res));
            compare("status", BYTE_W'(want.status), BYTE_W'(got.status));
            compare("rx_byte", want.rx_byte, got.rx_byte);
            compare("rx_end", BYTE_W'(want.rx_end), BYTE_W'(got.rx_end));
        endfunction

        function int unsigned pending();
            return due_levels.size();
        endfunction

        function void close_out();
            if (due_levels.size() != 0) begin
                $error("%0d ticks never produced an output transfer", due_levels.size());
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_action;
    logic [BYTE_W-1:0]    i_tx_byte;
    logic                 i_tx_end;
    logic                 i_nrfd_line;
    logic                 i_ndac_line;
    logic                 i_dav_line;
    logic                 i_eoi_line;
    logic [BYTE_W-1:0]    i_dio_lines;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_dav_drive;
    logic                 o_eoi_drive;
    logic                 o_nrfd_drive;
    logic                 o_ndac_drive;
    logic [BYTE_W-1:0]    o_dio_drive;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic                 o_status;
    logic [BYTE_W-1:0]    o_rx_byte;
    logic                 o_rx_end;

    handshake_predictor sb = new();
    int unsigned        ticks_sent = 0;
    bit                 in_calm = 1'b0;

    gpib_byte_handshake DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_tx_byte    (i_tx_byte),
        .i_tx_end     (i_tx_end),
        .i_nrfd_line  (i_nrfd_line),
        .i_ndac_line  (i_ndac_line),
        .i_dav_line   (i_dav_line),
        .i_eoi_line   (i_eoi_line),
        .i_dio_lines  (i_dio_lines),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dav_drive  (o_dav_drive),
        .o_eoi_drive  (o_eoi_drive),
        .o_nrfd_drive (o_nrfd_drive),
        .o_ndac_drive (o_ndac_drive),
        .o_dio_drive  (o_dio_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .o_rx_byte    (o_rx_byte),
        .o_rx_end     (o_rx_end)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // End the run if it hangs
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Check output transfers and stall the output side at random
    initial begin
        int unsigned stall_left;
        bit          out_calm;
        stall_left = 0;
        out_calm   = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_levels({o_dav_drive, o_eoi_drive, o_nrfd_drive, o_ndac_drive,
                                 o_dio_drive, o_busy_res, o_done_res, o_status,
                                 o_rx_byte, o_rx_end});
            if (stall_left != 0)
                stall_left--;
            else if (!out_calm && $urandom_range(0, 4) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
            if ($urandom_range(0, 99) == 0)
                out_calm = !out_calm;
            i_out_ready <= i_rst_n && (stall_left == 0);
        end
    end

    function automatic bus_tick_t bus_item(logic [1:0] act, logic [7:0] byte_val,
                                           logic eot, logic nrfd, logic ndac,
                                           logic dav, logic eoi, logic [7:0] dio);
        bus_tick_t t;
        t.action  = act;
        t.tx_byte = byte_val;
        t.tx_end  = eot;
        t.nrfd    = nrfd;
        t.ndac    = ndac;
        t.dav     = dav;
        t.eoi     = eoi;
        t.dio     = dio;
        return t;
    endfunction

    // Play the far end of the bus: meet the pending wait with odds 1 in odds
    function automatic bus_tick_t bus_response(int unsigned odds);
        bus_tick_t t;
        logic      hit;
        t   = bus_tick_t'($urandom);
        hit = ($urandom_range(1, odds) == 1);
        // mostly plain ticks; now and then a start that must be ignored
        if ($urandom_range(0, 7) != 0)
            t.action = ACT_TICK;
        case (sb.phase)
            PH_W_NRFD:  t.nrfd = hit;
            PH_W_NDAC:  t.ndac = hit;
            PH_R_DAVLO: t.dav  = !hit;
            PH_R_DAVHI: t.dav  = hit;
            default: ;
        endcase
        return t;
    endfunction

    // Present one tick and hold it until the block takes the transfer
    task automatic send_tick(bus_tick_t t);
        int unsigned gap;
        gap = 0;
        if (!in_calm) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gap = 0;
                6, 7, 8:          gap = $urandom_range(1, 3);
                default:          gap = $urandom_range(8, 30);
            endcase
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_action    <= t.action;
        i_tx_byte   <= t.tx_byte;
        i_tx_end    <= t.tx_end;
        i_nrfd_line <= t.nrfd;
        i_ndac_line <= t.ndac;
        i_dav_line  <= t.dav;
        i_eoi_line  <= t.eoi;
        i_dio_lines <= t.dio;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(t);
        ticks_sent++;
        if ($urandom_range(0, 59) == 0)
            in_calm = !in_calm;
    endtask

    // Start a byte transfer and answer the lines until the engine is idle
    task automatic run_transfer(logic [1:0] act, int unsigned odds);
        bus_tick_t t;
        t = bus_tick_t'($urandom);
        t.action = act;
        send_tick(t);
        while (sb.phase != PH_IDLE)
            send_tick(bus_response(odds));
    endtask

    // Mix of writes, reads and stray ticks; slow far ends provoke timeouts
    task automatic run_traffic(int unsigned count);
        int unsigned first;
        int unsigned pick;
        int unsigned odds;
        bus_tick_t   t;
        first = ticks_sent;
        while (ticks_sent - first < count) begin
            pick = $urandom_range(0, 19);
            odds = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            if (pick < 2) begin
                t = bus_tick_t'($urandom);
                if (pick == 0)
                    t.action = ACT_TICK;
                else
                    t.action = ACT_UNUSED;
                send_tick(t);
            end else if (pick < 11) begin
                run_transfer(ACT_WRITE, odds);
            end else begin
                run_transfer(ACT_READ, odds);
            end
        end
    endtask

    // Write both registers once the block has drained
    task automatic set_regs(logic [TIMER_W-1:0] timeout, logic [BYTE_W-1:0] settle);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= timeout;
        @(posedge i_clk);
        i_cfg_index <= CFG_SETTLE;
        i_cfg_data  <= {24'd0, settle};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.configure(timeout, settle);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_TICK;
        i_tx_byte   <= '0;
        i_tx_end    <= 1'b0;
        i_nrfd_line <= 1'b1;
        i_ndac_line <= 1'b1;
        i_dav_line  <= 1'b1;
        i_eoi_line  <= 1'b1;
        i_dio_lines <= BYTE_RELEASED;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle ticks, including the unused action code
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        // write 0x00 with EOI; a read start while busy is ignored
        send_tick(bus_item(ACT_WRITE, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_TICK, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'h5A));
        send_tick(bus_item(ACT_READ, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_WRITE, 8'h33, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF));
        // write 0xFF without EOI, far end ready at once
        send_tick(bus_item(ACT_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF));
        // read all-ones with EOI, then all-zeros without
        send_tick(bus_item(ACT_READ, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00));
        send_tick(bus_item(ACT_WRITE, 8'hAA, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
        send_tick(bus_item(ACT_READ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF));
        send_tick(bus_item(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));

        // timeout at its floor, settle zero behaves as one
        set_regs('0, 8'd0);
        run_traffic(90);
        // timeout that never fires, longest settle
        set_regs(TIMER_MAX, 8'hFF);
        run_transfer(ACT_WRITE, 2);
        repeat (3) run_transfer(ACT_READ, 2);
        set_regs(32'd1, 8'd1);
        run_traffic(90);
        set_regs(TIMER_W'($urandom_range(2, 12)), BYTE_W'($urandom_range(2, 5)));
        run_traffic(90);
        set_regs(TIMER_W'($urandom_range(0, 40)), BYTE_W'($urandom_range(0, 8)));
        run_traffic(90);

        // drain, then report
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
